// ===== design/nwc_pkg.sv =====
`default_nettype none

package nwc_pkg;

    localparam int MAX_WINDOW_DEF = 7;

    localparam int INDEX_W  = 9;
    localparam int WEIGHT_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int WSUM_W   = 41;
    localparam int WTOT_W   = 24;
    localparam int ALU_W    = WSUM_W + 1;

    // one step per multiplier bit, one step per dividend bit
    localparam int MUL_STEPS = WEIGHT_W;
    localparam int DIV_STEPS = WSUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic sample_go;
        logic fetch_mul;
        logic last;
        logic wtot_zero;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic ready;
        logic fetch;
        logic mul_step;
        logic abs_load;
        logic div_step;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== design/normalized_window_convolution.sv =====
`default_nettype none

// Coverage-normalized weighted average over a cubic window of MAX_WINDOW^3
// positions. Load requests (kind 0) write Q1.15 weights into the weight RAM and
// leave the block ready; load indexes past the RAM are dropped. Sample
// requests walk the window in inline, crossline, time order, and the request
// flagged last emits sum(sample*weight) / sum(weight), truncated toward zero
// and saturated to 16 bits; defined is 0 when no weight was accumulated. The
// sums, products, magnitude and divide run through one 42-bit add/subtract
// unit: a sample request occupies the block for a RAM read when absent or past
// the window end, and for a RAM read then 16 shift-add multiply steps when
// present. The last request then adds a magnitude step, 41 restoring divide
// steps and an output load, with no divide when no weight was accumulated; the
// output load waits while stall holds an earlier result. The RAM has no
// clearing pass: every position used by a window must be loaded first.
module normalized_window_convolution #(
    parameter int MAX_WINDOW = nwc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic [nwc_pkg::INDEX_W-1:0]   i_weight_index,
    input  wire logic [nwc_pkg::WEIGHT_W-1:0]  i_weight_value,
    input  wire logic signed [nwc_pkg::SAMPLE_W-1:0] i_sample_value,
    input  wire logic                          i_sample_present,
    input  wire logic                          i_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [nwc_pkg::SAMPLE_W-1:0] o_filtered_value,
    output logic                               o_defined
);

    localparam int DEPTH = MAX_WINDOW * MAX_WINDOW * MAX_WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    localparam int WSUM_W   = nwc_pkg::WSUM_W;
    localparam int WTOT_W   = nwc_pkg::WTOT_W;
    localparam int WEIGHT_W = nwc_pkg::WEIGHT_W;
    localparam int SAMPLE_W = nwc_pkg::SAMPLE_W;
    localparam int ALU_W    = nwc_pkg::ALU_W;

    nwc_pkg::t_ctrl     ctrl;
    nwc_pkg::t_status   status;
    nwc_pkg::t_alu_op   alu_op;

    logic                  w_in_accept;
    logic                  w_we;
    logic [WEIGHT_W-1:0]   w_rdata;
    logic [ALU_W-1:0]      w_alu_a;
    logic [ALU_W-1:0]      w_alu_b;
    logic [ALU_W-1:0]      w_alu_y;
    logic [WTOT_W:0]       w_partial;
    logic                  w_ge;
    logic                  w_pos_ok;
    logic                  w_big;
    logic [SAMPLE_W-1:0]   w_sat;

    // window state
    logic [PW-1:0]         r_pos;
    logic [WSUM_W-1:0]     r_acc;
    logic [WTOT_W-1:0]     r_wtot;
    logic                  r_out_valid;

    // per-item working registers
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                  r_present;
    logic                  r_last;
    logic [WSUM_W-1:0]     r_mcand;
    logic [WEIGHT_W-1:0]   r_mplier;
    logic [WSUM_W-1:0]     r_quo;
    logic [WTOT_W-1:0]     r_rem;
    logic                  r_neg;
    logic [SAMPLE_W-1:0]   r_out_value;
    logic                  r_out_defined;

    assign w_in_accept = i_in_valid && ctrl.ready;
    assign o_in_stall  = !ctrl.ready;
    assign w_we        = w_in_accept && (i_kind == nwc_pkg::KIND_LOAD)
                         && (32'(i_weight_index) < DEPTH);
    assign w_pos_ok    = (32'(r_pos) < DEPTH);

    assign status.sample_go = w_in_accept && (i_kind == nwc_pkg::KIND_SAMPLE);
    assign status.fetch_mul = r_present && w_pos_ok;
    assign status.last      = r_last;
    assign status.wtot_zero = (r_wtot == '0);
    assign status.out_free  = !r_out_valid || !i_out_stall;

    nwc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    nwc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_weight_index)),
        .i_wdata (i_weight_value),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // remainder shifted left with the next dividend bit
    assign w_partial = {r_rem, r_quo[WSUM_W-1]};

    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        alu_op  = nwc_pkg::ALU_ADD;
        if (ctrl.fetch) begin
            w_alu_a = ALU_W'(r_wtot);
            w_alu_b = ALU_W'(w_rdata);
        end else if (ctrl.mul_step) begin
            w_alu_a = ALU_W'(r_acc);
            w_alu_b = r_mplier[0] ? ALU_W'(r_mcand) : '0;
        end else if (ctrl.abs_load) begin
            alu_op  = nwc_pkg::ALU_SUB;
            w_alu_b = ALU_W'(r_acc);
        end else if (ctrl.div_step) begin
            alu_op  = nwc_pkg::ALU_SUB;
            w_alu_a = ALU_W'(w_partial);
            w_alu_b = ALU_W'(r_wtot);
        end
    end

    nwc_alu u_alu (
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .i_op (alu_op),
        .o_y  (w_alu_y)
    );

    assign w_ge  = !w_alu_y[ALU_W-1];
    assign w_big = |r_quo[WSUM_W-1:SAMPLE_W-1];

    always_comb begin
        if (r_wtot == '0) begin
            w_sat = '0;
        end else if (r_neg) begin
            w_sat = w_big ? nwc_pkg::SAT_MIN : (~r_quo[SAMPLE_W-1:0] + 1'b1);
        end else begin
            w_sat = w_big ? nwc_pkg::SAT_MAX : r_quo[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_acc       <= '0;
            r_wtot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.fetch) begin
                if (status.fetch_mul) r_wtot <= w_alu_y[WTOT_W-1:0];
                if (w_pos_ok)         r_pos  <= r_pos + 1'b1;
            end
            if (ctrl.mul_step) begin
                r_acc <= w_alu_y[WSUM_W-1:0];
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
                r_pos       <= '0;
                r_acc       <= '0;
                r_wtot      <= '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.sample_go) begin
            r_sample  <= i_sample_value;
            r_present <= i_sample_present;
            r_last    <= i_last;
        end
        if (ctrl.fetch) begin
            r_mcand  <= {{(WSUM_W - SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
            r_mplier <= w_rdata;
        end
        if (ctrl.mul_step) begin
            r_mcand  <= {r_mcand[WSUM_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[WEIGHT_W-1:1]};
        end
        if (ctrl.abs_load) begin
            r_neg <= r_acc[WSUM_W-1];
            r_quo <= r_acc[WSUM_W-1] ? w_alu_y[WSUM_W-1:0] : r_acc;
            r_rem <= '0;
        end
        if (ctrl.div_step) begin
            r_rem <= w_ge ? w_alu_y[WTOT_W-1:0] : w_partial[WTOT_W-1:0];
            r_quo <= {r_quo[WSUM_W-2:0], w_ge};
        end
        if (ctrl.out_load) begin
            r_out_value   <= w_sat;
            r_out_defined <= (r_wtot != '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_defined        = r_out_defined;

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && (i_kind == nwc_pkg::KIND_LOAD) |=> !o_in_stall)
        else $error("load request left the block busy");

    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> (r_pos == '0) && (r_acc == '0) && (r_wtot == '0))
        else $error("window state not cleared after result");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= DEPTH)
        else $error("window position past weight store");

    a_absent_keeps_wtot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fetch && !r_present |=> $stable(r_wtot) && $stable(r_acc))
        else $error("absent sample changed the sums");

endmodule

`default_nettype wire

// ===== design/nwc_ram.sv =====
`default_nettype none

module nwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 343
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/nwc_alu.sv =====
`default_nettype none

module nwc_alu (
    input  wire logic [nwc_pkg::ALU_W-1:0] i_a,
    input  wire logic [nwc_pkg::ALU_W-1:0] i_b,
    input  wire nwc_pkg::t_alu_op          i_op,
    output logic      [nwc_pkg::ALU_W-1:0] o_y
);

    always_comb begin
        case (i_op)
            nwc_pkg::ALU_ADD: o_y = i_a + i_b;
            nwc_pkg::ALU_SUB: o_y = i_a - i_b;
            default:          o_y = i_a + i_b;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/nwc_seq.sv =====
`default_nettype none

module nwc_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire nwc_pkg::t_status i_status,
    output nwc_pkg::t_ctrl        o_ctrl
);

    nwc_pkg::t_state                r_state;
    nwc_pkg::t_state                n_state;
    logic [nwc_pkg::CNT_W-1:0]      r_cnt;
    logic [nwc_pkg::CNT_W-1:0]      n_cnt;
    logic                           w_mul_done;
    logic                           w_div_done;

    assign w_mul_done = (r_cnt == nwc_pkg::CNT_W'(nwc_pkg::MUL_STEPS - 1));
    assign w_div_done = (r_cnt == nwc_pkg::CNT_W'(nwc_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwc_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nwc_pkg::ST_IDLE: begin
                if (i_status.sample_go) n_state = nwc_pkg::ST_FETCH;
            end
            nwc_pkg::ST_FETCH: begin
                if (i_status.fetch_mul) n_state = nwc_pkg::ST_MUL;
                else if (i_status.last) n_state = nwc_pkg::ST_ABS;
                else                    n_state = nwc_pkg::ST_IDLE;
            end
            nwc_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_state = i_status.last ? nwc_pkg::ST_ABS : nwc_pkg::ST_IDLE;
                end
            end
            nwc_pkg::ST_ABS: begin
                // empty coverage skips the divide
                n_state = i_status.wtot_zero ? nwc_pkg::ST_OUT : nwc_pkg::ST_DIV;
            end
            nwc_pkg::ST_DIV: begin
                if (w_div_done) n_state = nwc_pkg::ST_OUT;
            end
            nwc_pkg::ST_OUT: begin
                if (i_status.out_free) n_state = nwc_pkg::ST_IDLE;
            end
            default: n_state = nwc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            nwc_pkg::ST_MUL: n_cnt = w_mul_done ? '0 : r_cnt + 1'b1;
            nwc_pkg::ST_DIV: n_cnt = w_div_done ? '0 : r_cnt + 1'b1;
            default:         n_cnt = '0;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            nwc_pkg::ST_IDLE:  o_ctrl.ready    = 1'b1;
            nwc_pkg::ST_FETCH: o_ctrl.fetch    = 1'b1;
            nwc_pkg::ST_MUL:   o_ctrl.mul_step = 1'b1;
            nwc_pkg::ST_ABS:   o_ctrl.abs_load = 1'b1;
            nwc_pkg::ST_DIV:   o_ctrl.div_step = 1'b1;
            nwc_pkg::ST_OUT:   o_ctrl.out_load = i_status.out_free;
            default:           o_ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire
